// File: rtl/lefc_pkg.sv
package lefc_pkg;

    // Field widths of the pixel stream and the result items.
    localparam int PIX_W      = 8;
    localparam int COL_W      = 11;
    localparam int ROW_W      = 12;
    localparam int CFG_WID_W  = 12;
    localparam int CFG_HGT_W  = 13;
    localparam int CFG_DATA_W = 13;

    // Register indexes of the configuration port.
    localparam logic CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic CFG_IMAGE_HEIGHT = 1'b1;

    // Register values after reset.
    localparam logic [CFG_WID_W-1:0] RESET_WIDTH  = 12'd640;
    localparam logic [CFG_HGT_W-1:0] RESET_HEIGHT = 13'd480;

    // Smallest frame side the filter accepts.
    localparam logic [CFG_WID_W-1:0] MIN_WIDTH  = 12'd3;
    localparam logic [CFG_HGT_W-1:0] MIN_HEIGHT = 13'd3;

    // Output queue sizing.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_CNT_W = 3;

    typedef logic [PIX_W-1:0] t_pixel;

    // Control carried along the pipeline with each item.
    typedef struct packed {
        logic             emit;
        logic             last;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } t_ctl;

    // One result item as held in the output queue.
    typedef struct packed {
        t_pixel           edge_value;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             frame_last;
    } t_result;

endpackage

// File: rtl/lefc_line_store.sv
module lefc_line_store #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  logic                  i_clk,
    input  logic                  i_rd_en,
    input  logic [AW-1:0]         i_rd_addr,
    input  logic                  i_wr_en,
    input  logic [AW-1:0]         i_wr_addr,
    input  lefc_pkg::t_pixel      i_wr_px,
    output lefc_pkg::t_pixel      o_up,
    output lefc_pkg::t_pixel      o_mid
);
    import lefc_pkg::*;

    t_pixel r_mem_upper  [DEPTH];
    t_pixel r_mem_middle [DEPTH];
    t_pixel r_up;
    t_pixel r_mid;

    // Read both rows of the column; the data is registered.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_up  <= r_mem_upper[i_rd_addr];
            r_mid <= r_mem_middle[i_rd_addr];
        end
    end

    // Write back in the cycle after the read: the middle row moves up, the new pixel goes in.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem_upper[i_wr_addr]  <= r_mid;
            r_mem_middle[i_wr_addr] <= i_wr_px;
        end
    end

    assign o_up  = r_up;
    assign o_mid = r_mid;

endmodule

// File: rtl/lefc_window.sv
module lefc_window (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_shift,
    input  lefc_pkg::t_pixel  i_up,
    input  lefc_pkg::t_pixel  i_mid,
    input  lefc_pkg::t_pixel  i_px,
    input  lefc_pkg::t_ctl    i_ctl,
    output logic              o_vld,
    output lefc_pkg::t_ctl    o_ctl,
    output lefc_pkg::t_pixel  o_edge_value
);
    import lefc_pkg::*;

    t_pixel           r_win [9];
    logic             r_vld;
    t_ctl             r_ctl;
    logic [10:0]      nbr_sum;
    logic [10:0]      ctr_x8;
    logic signed [11:0] diff;

    // Shift the 3x3 window left and load the new column on the right.
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            for (int k = 0; k < 3; k++) begin
                r_win[k*3]   <= r_win[k*3+1];
                r_win[k*3+1] <= r_win[k*3+2];
            end
            r_win[2] <= i_up;
            r_win[5] <= i_mid;
            r_win[8] <= i_px;
            r_ctl    <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_shift;
        end
    end

    // Kernel: eight times the center minus the eight neighbors.
    always_comb begin
        nbr_sum = 11'((11'(r_win[0]) + 11'(r_win[1])) + (11'(r_win[2]) + 11'(r_win[3])))
                + 11'((11'(r_win[5]) + 11'(r_win[6])) + (11'(r_win[7]) + 11'(r_win[8])));
        ctr_x8  = {r_win[4], 3'b000};
        diff    = $signed({1'b0, ctr_x8}) - $signed({1'b0, nbr_sum});
    end

    // Clamp the response to the pixel range.
    always_comb begin
        if (diff[11]) begin
            o_edge_value = '0;
        end else if (diff[10:8] != 3'b000) begin
            o_edge_value = '1;
        end else begin
            o_edge_value = diff[7:0];
        end
    end

    assign o_vld = r_vld;
    assign o_ctl = r_ctl;

endmodule

// File: rtl/lefc_out_fifo.sv
module lefc_out_fifo (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    input  lefc_pkg::t_result                   i_data,
    input  logic                                i_pop,
    output logic                                o_valid,
    output lefc_pkg::t_result                   o_data,
    output logic [lefc_pkg::FIFO_CNT_W-1:0]     o_count
);
    import lefc_pkg::*;

    t_result               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]    r_wr_ptr;
    logic [FIFO_AW-1:0]    r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count;
    logic                  do_pop;

    assign do_pop = i_pop && (r_count != '0);

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

// File: rtl/laplacian_edge_filter_3x3_core.sv
// A pixel passes the line store read and stage 1, then window shift and kernel
// (stage 2) into the output queue. Throughput: 1 pixel per cycle while the
// queue has room for all items in flight, set by the single read and write port of
// each line store; a 4-entry output queue keeps input flowing while the output stalls.
// Reset: counters and queue clear, size registers load 640 x 480;
// the line stores are not cleared and are filled by the first two rows.
module laplacian_edge_filter_3x3_core #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Pixel input channel
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [lefc_pkg::PIX_W-1:0]          i_pixel,
    // Result output channel
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [lefc_pkg::PIX_W-1:0]          o_edge_value,
    output logic [lefc_pkg::COL_W-1:0]          o_out_col,
    output logic [lefc_pkg::ROW_W-1:0]          o_out_row,
    output logic                                o_frame_last,
    // Configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic                                i_cfg_index,
    input  logic [lefc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import lefc_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);

    logic [CFG_WID_W-1:0]  r_image_width;
    logic [CFG_HGT_W-1:0]  r_image_height;
    logic [COL_W-1:0]      r_col_cnt;
    logic [ROW_W-1:0]      r_row_cnt;
    logic [COL_W-1:0]      n_col_cnt;
    logic [ROW_W-1:0]      n_row_cnt;

    logic [CFG_WID_W-1:0]  w_lim;
    logic [CFG_HGT_W-1:0]  h_lim;
    logic [CFG_WID_W-1:0]  col_ext;
    logic [CFG_HGT_W-1:0]  row_ext;
    logic [CFG_WID_W-1:0]  col_inc;
    logic [CFG_HGT_W-1:0]  row_inc;
    logic                  in_acc;
    t_ctl                  ctl_now;

    logic                  r_s1_vld;
    logic                  r_s1_wen;
    logic [AW-1:0]         r_s1_addr;
    t_pixel                r_s1_px;
    t_ctl                  r_s1_ctl;

    t_pixel                ls_up;
    t_pixel                ls_mid;
    logic                  s2_vld;
    t_ctl                  s2_ctl;
    t_pixel                s2_edge;
    t_result               push_data;
    t_result               q_data;
    logic [FIFO_CNT_W-1:0] q_count;
    logic [FIFO_CNT_W-1:0] in_flight;

    // Configuration registers; writes are always taken.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= RESET_WIDTH;
            r_image_height <= RESET_HEIGHT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data[CFG_WID_W-1:0];
                CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data;
                default:          r_image_width  <= r_image_width;
            endcase
        end
    end

    // Frame size in use, clamped to the supported range.
    always_comb begin
        if (r_image_width < MIN_WIDTH) begin
            w_lim = MIN_WIDTH;
        end else if (32'(r_image_width) > MAX_WIDTH) begin
            w_lim = CFG_WID_W'(MAX_WIDTH);
        end else begin
            w_lim = r_image_width;
        end
        if (r_image_height < MIN_HEIGHT) begin
            h_lim = MIN_HEIGHT;
        end else if (32'(r_image_height) > MAX_HEIGHT) begin
            h_lim = CFG_HGT_W'(MAX_HEIGHT);
        end else begin
            h_lim = r_image_height;
        end
    end

    // Credit check: every item in flight must find room in the output queue.
    assign in_flight  = q_count + FIFO_CNT_W'(r_s1_vld) + FIFO_CNT_W'(s2_vld);
    assign o_in_ready = (in_flight < FIFO_CNT_W'(FIFO_DEPTH));
    assign in_acc     = i_in_valid && o_in_ready;

    // Emit decision and raster counter advance for the item at the input.
    always_comb begin
        col_ext = {1'b0, r_col_cnt};
        row_ext = {1'b0, r_row_cnt};
        ctl_now.emit = (r_row_cnt >= ROW_W'(2)) && (r_col_cnt >= COL_W'(2))
                    && (row_ext < h_lim) && (col_ext < w_lim);
        ctl_now.last = (row_ext == h_lim - 1'b1) && (col_ext == w_lim - 1'b1);
        ctl_now.col  = r_col_cnt - 1'b1;
        ctl_now.row  = r_row_cnt - 1'b1;

        col_inc = col_ext + 1'b1;
        row_inc = row_ext + 1'b1;
        if (col_inc >= w_lim) begin
            n_col_cnt = '0;
            n_row_cnt = (row_inc >= h_lim) ? '0 : row_inc[ROW_W-1:0];
        end else begin
            n_col_cnt = col_inc[COL_W-1:0];
            n_row_cnt = (row_ext >= h_lim) ? '0 : r_row_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_cnt <= '0;
            r_row_cnt <= '0;
        end else if (in_acc) begin
            r_col_cnt <= n_col_cnt;
            r_row_cnt <= n_row_cnt;
        end
    end

    // Stage 1: hold the pixel while the line stores are read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_px   <= i_pixel;
            r_s1_addr <= AW'(r_col_cnt);
            r_s1_wen  <= (32'(r_col_cnt) < MAX_WIDTH);
            r_s1_ctl  <= ctl_now;
        end
    end

    lefc_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (AW)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_rd_en   (in_acc),
        .i_rd_addr (AW'(r_col_cnt)),
        .i_wr_en   (r_s1_vld && r_s1_wen),
        .i_wr_addr (r_s1_addr),
        .i_wr_px   (r_s1_px),
        .o_up      (ls_up),
        .o_mid     (ls_mid)
    );

    // Stage 2: window and kernel.
    lefc_window u_window (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_shift      (r_s1_vld),
        .i_up         (ls_up),
        .i_mid        (ls_mid),
        .i_px         (r_s1_px),
        .i_ctl        (r_s1_ctl),
        .o_vld        (s2_vld),
        .o_ctl        (s2_ctl),
        .o_edge_value (s2_edge)
    );

    // Interior pixels go to the output queue.
    always_comb begin
        push_data.edge_value = s2_edge;
        push_data.col        = s2_ctl.col;
        push_data.row        = s2_ctl.row;
        push_data.frame_last = s2_ctl.last;
    end

    lefc_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s2_vld && s2_ctl.emit),
        .i_data  (push_data),
        .i_pop   (i_out_ready),
        .o_valid (o_out_valid),
        .o_data  (q_data),
        .o_count (q_count)
    );

    assign o_edge_value = q_data.edge_value;
    assign o_out_col    = q_data.col;
    assign o_out_row    = q_data.row;
    assign o_frame_last = q_data.frame_last;

`ifndef SYNTHESIS
    // The queue never holds more items than it has entries.
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("output queue overfilled");

    // A line store read never hits the column being written back.
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_s1_vld && r_s1_wen) |-> (r_s1_addr != AW'(r_col_cnt)))
        else $error("line store read and write to the same column");

    // An accepted interior pixel reaches the queue input through the stage 1 and window registers.
    a_emit_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && ctl_now.emit) |=> ##1 (s2_vld && s2_ctl.emit))
        else $error("interior pixel lost in the pipeline");

    // A pushed result never lies on the frame border.
    a_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s2_vld && s2_ctl.emit) |-> (s2_ctl.col != '0 && s2_ctl.row != '0))
        else $error("border pixel pushed as a result");
`endif

endmodule

// File: tb/tb.sv
module tb;
    import lefc_pkg::*;

    localparam int MAX_W         = 2048;
    localparam int MAX_H         = 4096;
    localparam int RANDOM_ITEMS  = 960;
    localparam int WIDE_ITEMS    = 64;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 64;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int LIMIT_CYCLES  = 1_000_000;

    // Kernel weight of the center pixel and the top of the output range.
    localparam int CENTER_WEIGHT = 8;
    localparam int EDGE_MAX      = 255;

    // Tracks the filter state and holds the edge results still to arrive.
    class laplacian_tracker;
        logic [CFG_WID_W-1:0] width_reg;
        logic [CFG_HGT_W-1:0] height_reg;
        t_pixel               two_rows_up [MAX_W];
        t_pixel               one_row_up [MAX_W];
        t_pixel               win [9];
        logic [COL_W-1:0]     col;
        logic [ROW_W-1:0]     row;
        t_result              edges_due [$];
        int                   errors;

        function void clear();
            width_reg  = RESET_WIDTH;
            height_reg = RESET_HEIGHT;
            foreach (two_rows_up[i]) begin
                two_rows_up[i] = '0;
                one_row_up[i]  = '0;
            end
            foreach (win[i]) win[i] = '0;
            col    = '0;
            row    = '0;
            errors = 0;
            edges_due.delete();
        endfunction

        function int unsigned size_used(int unsigned v, int unsigned lo, int unsigned hi);
            if (v < lo) return lo;
            if (v > hi) return hi;
            return v;
        endfunction

        function int unsigned frame_width();
            return size_used(width_reg, MIN_WIDTH, MAX_W);
        endfunction

        function int unsigned frame_height();
            return size_used(height_reg, MIN_HEIGHT, MAX_H);
        endfunction

        function void write_reg(logic idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_IMAGE_WIDTH) begin
                width_reg = data[CFG_WID_W-1:0];
            end else begin
                height_reg = data;
            end
        endfunction

        // Advances the filter by one pixel and queues the edge result it yields.
        function void take_pixel(t_pixel px);
            int unsigned w, h, c, r;
            t_pixel      up, mid;
            int          sum, k;
            t_result     res;
            w = frame_width();
            h = frame_height();
            c = col;
            r = row;
            // Read the two rows above this column, then move the column up a row.
            up              = two_rows_up[c];
            mid             = one_row_up[c];
            two_rows_up[c]  = mid;
            one_row_up[c]   = px;
            // Shift the window left and bring in the new column.
            for (k = 0; k < 3; k++) begin
                win[k*3]   = win[k*3+1];
                win[k*3+1] = win[k*3+2];
            end
            win[2] = up;
            win[5] = mid;
            win[8] = px;
            // The window is complete over an interior pixel.
            if (r >= 2 && c >= 2 && r < h && c < w) begin
                sum = CENTER_WEIGHT * int'(win[4]);
                for (k = 0; k < 9; k++) begin
                    if (k != 4) sum -= int'(win[k]);
                end
                if (sum > EDGE_MAX) sum = EDGE_MAX;
                if (sum < 0) sum = 0;
                res.edge_value = t_pixel'(sum);
                res.col        = COL_W'(c - 1);
                res.row        = ROW_W'(r - 1);
                res.frame_last = (r == h - 1) && (c == w - 1);
                edges_due.push_back(res);
            end
            // Raster counters; a counter beyond a shrunken size wraps on this step.
            c++;
            if (c >= w) begin
                c = 0;
                r++;
                if (r >= h) r = 0;
            end else if (r >= h) begin
                r = 0;
            end
            col = COL_W'(c);
            row = ROW_W'(r);
        endfunction

        // Compares one accepted result item with the oldest expected edge.
        function void match_edge(t_pixel ev, logic [COL_W-1:0] oc, logic [ROW_W-1:0] orow,
                                 logic last);
            t_result want;
            if (edges_due.size() == 0) begin
                $error("unexpected result item at col %0d row %0d", oc, orow);
                errors++;
                return;
            end
            want = edges_due.pop_front();
            if (ev !== want.edge_value) begin
                $error("edge_value: expected %0d, got %0d", want.edge_value, ev);
                errors++;
            end
            if (oc !== want.col) begin
                $error("out_col: expected %0d, got %0d", want.col, oc);
                errors++;
            end
            if (orow !== want.row) begin
                $error("out_row: expected %0d, got %0d", want.row, orow);
                errors++;
            end
            if (last !== want.frame_last) begin
                $error("frame_last: expected %0d, got %0d", want.frame_last, last);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_pixel                i_pixel;
    logic                  o_out_valid;
    logic                  i_out_ready;
    t_pixel                o_edge_value;
    logic [COL_W-1:0]      o_out_col;
    logic [ROW_W-1:0]      o_out_row;
    logic                  o_frame_last;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic                  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int tx_gap_max;
    int rx_gap_max;
    int pixels_sent;
    bit rx_hold;

    laplacian_tracker tracker = new;

    laplacian_edge_filter_3x3_core #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_pixel      (i_pixel),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_edge_value (o_edge_value),
        .o_out_col    (o_out_col),
        .o_out_row    (o_out_row),
        .o_frame_last (o_frame_last),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Pixels lean toward black and white so both ends of the clamp are hit.
    function automatic t_pixel rand_pixel();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            default: return t_pixel'($urandom_range(0, 255));
        endcase
    endfunction

    // Small widths, some below the minimum, some with the unused top bit set.
    function automatic logic [CFG_DATA_W-1:0] rand_width_value();
        case ($urandom_range(0, 5))
            0: return CFG_DATA_W'($urandom_range(0, 2));
            1: return {1'b1, CFG_WID_W'($urandom_range(3, 10))};
            default: return CFG_DATA_W'($urandom_range(3, 10));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_height_value();
        case ($urandom_range(0, 5))
            0: return CFG_DATA_W'($urandom_range(0, 2));
            1: return CFG_DATA_W'($urandom_range(11, 14));
            default: return CFG_DATA_W'($urandom_range(3, 10));
        endcase
    endfunction

    // Offers one pixel item after a random gap and waits for it to be taken.
    task automatic send_pixel(t_pixel px);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_pixel    <= px;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        tracker.take_pixel(px);
        pixels_sent++;
    endtask

    // Writes one register; valid stays up when another write follows at once.
    task automatic cfg_write(logic idx, logic [CFG_DATA_W-1:0] data, bit last);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        tracker.write_reg(idx, data);
        if (last) i_cfg_valid <= 1'b0;
    endtask

    task automatic set_size(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h);
        cfg_write(CFG_IMAGE_WIDTH, w, 1'b0);
        cfg_write(CFG_IMAGE_HEIGHT, h, 1'b1);
    endtask

    // Stops the input and lets the pipeline empty before a register write.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (tracker.edges_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic finish_frame();
        while (tracker.col != 0 || tracker.row != 0) send_pixel(rand_pixel());
    endtask

    // Result side: random stalls, plus one long hold-off when asked for.
    initial begin : result_sink
        int gap;
        i_out_ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (rx_hold) begin
                rx_hold = 1'b0;
                gap     = HOLD_CYCLES;
            end else begin
                gap = $urandom_range(0, rx_gap_max);
            end
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            tracker.match_edge(o_edge_value, o_out_col, o_out_row, o_frame_last);
        end
    end

    // Stimulus sequence.
    initial begin : stimulus
        int target;
        int phase;
        int n;
        tracker.clear();
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_pixel     <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_IMAGE_WIDTH;
        i_cfg_data  <= '0;
        tx_gap_max  = 7;
        rx_gap_max  = 7;
        rx_hold     = 1'b0;
        pixels_sent = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Start of row 0 at the reset size.
        repeat (3) send_pixel('1);
        settle();
        // Both sizes below the minimum, so the frame is 3 x 3 for the directed steps below.
        set_size(CFG_DATA_W'(2), CFG_DATA_W'(0));
        // Column 3 lies beyond the new width, so row 0 ends with this item.
        send_pixel(rand_pixel());
        // Dark center among bright neighbors clamps to 0.
        send_pixel('1);
        send_pixel('0);
        send_pixel('1);
        repeat (3) send_pixel('1);
        // Next frame keeps the stores; bright center on black clamps to 255.
        repeat (4) send_pixel('0);
        send_pixel('1);
        repeat (4) send_pixel('0);

        // Random phases of small frames with size changes in between.
        target = pixels_sent + RANDOM_ITEMS;
        phase  = 0;
        while (pixels_sent < target) begin
            if ($urandom_range(0, 2) == 0) finish_frame();
            settle();
            if (tracker.col == 0 && tracker.row == 0) begin
                case ($urandom_range(0, 3))
                    0: cfg_write(CFG_IMAGE_WIDTH, rand_width_value(), 1'b1);
                    1: cfg_write(CFG_IMAGE_HEIGHT, rand_height_value(), 1'b1);
                    2: set_size(rand_width_value(), rand_height_value());
                    default: ;
                endcase
            end else begin
                // Inside a frame the width never grows; the height may go anywhere.
                case ($urandom_range(0, 2))
                    0: cfg_write(CFG_IMAGE_HEIGHT, rand_height_value(), 1'b1);
                    1: cfg_write(CFG_IMAGE_WIDTH,
                                 CFG_DATA_W'($urandom_range(0, tracker.frame_width())), 1'b1);
                    default: ;
                endcase
            end
            tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 7;
            rx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 7;
            n = $urandom_range(1, 40);
            if (phase % 10 == 1) begin
                // Full-rate input against a held output fills the queue.
                tx_gap_max = 0;
                rx_hold    = 1'b1;
                n          = 60;
            end
            repeat (n) send_pixel(rand_pixel());
            phase++;
        end

        // Cut the current frame short, then open a frame at the largest size.
        settle();
        cfg_write(CFG_IMAGE_HEIGHT, CFG_DATA_W'(3), 1'b1);
        finish_frame();
        settle();
        set_size('1, '1);
        repeat (WIDE_ITEMS) send_pixel(rand_pixel());

        // Drain the remaining results and look for stragglers.
        i_in_valid <= 1'b0;
        for (int t = 0; t < DRAIN_LIMIT && tracker.edges_due.size() != 0; t++) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (tracker.edges_due.size() != 0) begin
            $error("%0d expected result items never arrived", tracker.edges_due.size());
            tracker.errors += tracker.edges_due.size();
        end
        if (tracker.errors == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

    // Watchdog.
    initial begin : watchdog
        repeat (LIMIT_CYCLES) @(posedge i_clk);
        $display("tb: errors");
        $finish;
    end

endmodule
